@@ hw/rtl/sis_pkg.sv @@
// Shared constants and types for the sorted id set insert block.
`timescale 1ns / 1ps

package sis_pkg;

  localparam int CAPACITY  = 256;
  localparam int ID_W      = 32;
  localparam int POS_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int STEP_W    = (POS_W > 1) ? $clog2(POS_W) : 1;
  localparam int OUT_POS_W = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SRCH,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/sorted_id_set_insert.sv @@
// Takes one word at a time: a new word is accepted only in the idle state, after the
//   previous result has been committed to the output register. Each word waits on the
//   bit-serial position search that reads one cell flag per cycle.
// Compare and insert-shift each run across all cells of the chain in parallel.
// Reset: asynchronous, active low; clears the entry count and all cell valid bits.
`timescale 1ns / 1ps

module sorted_id_set_insert (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sis_pkg::ID_W-1:0]        entity_id_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sis_pkg::OUT_POS_W-1:0]   insert_position_o,
  output logic                            inserted_o,
  output logic                            set_full_o
);

  sis_pkg::state_e            state_q;
  sis_pkg::state_e            state_d;
  sis_pkg::cell_ctrl_t        ctrl;
  logic [sis_pkg::ID_W-1:0]   id_q;
  logic [sis_pkg::POS_W-1:0]  count_q;
  logic [sis_pkg::POS_W-1:0]  pos;
  logic                       srch_start;
  logic                       srch_done;
  logic                       out_free;
  logic                       commit;
  logic                       dup;
  logic                       full;
  logic                       ins;
  logic                       accept;

  logic [sis_pkg::ID_W-1:0]   val_w [sis_pkg::CAPACITY];
  logic [sis_pkg::CAPACITY-1:0] above_w;
  logic [sis_pkg::CAPACITY-1:0] lt_w;
  logic [sis_pkg::CAPACITY-1:0] eq_w;

  logic                       out_valid_q;
  logic [sis_pkg::POS_W-1:0]  out_pos_q;
  logic                       out_ins_q;
  logic                       out_full_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sis_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sis_pkg::ST_CMP;
      end
      sis_pkg::ST_CMP: begin
        state_d = sis_pkg::ST_SRCH;
      end
      sis_pkg::ST_SRCH: begin
        if (srch_done) state_d = sis_pkg::ST_COMMIT;
      end
      sis_pkg::ST_COMMIT: begin
        if (out_free) state_d = sis_pkg::ST_IDLE;
      end
      default: state_d = sis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    srch_start  = 1'b0;
    commit      = 1'b0;
    case (state_q)
      sis_pkg::ST_IDLE:   in_stall_o = 1'b0;
      sis_pkg::ST_CMP:    srch_start = 1'b1;
      sis_pkg::ST_SRCH:   ;
      sis_pkg::ST_COMMIT: commit     = out_free;
      default:            ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sis_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q <= entity_id_i;
    end
  end

  assign dup  = (pos < count_q) && eq_w[pos[sis_pkg::IDX_W-1:0]];
  assign full = !dup && (count_q == sis_pkg::POS_W'(sis_pkg::CAPACITY));
  assign ins  = !dup && !full;

  assign ctrl.cmp_en = srch_start;
  assign ctrl.ins_en = commit && ins;

  genvar gi;
  generate
    for (gi = 0; gi < sis_pkg::CAPACITY; gi++) begin : g_cell
      logic [sis_pkg::ID_W-1:0] left_val;
      logic                     left_above;
      if (gi == 0) begin : g_head
        assign left_val   = '0;
        assign left_above = 1'b0;
      end else begin : g_link
        assign left_val   = val_w[gi-1];
        assign left_above = above_w[gi-1];
      end
      sis_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .id_i         (id_q),
        .left_val_i   (left_val),
        .left_above_i (left_above),
        .tail_i       (count_q == sis_pkg::POS_W'(gi)),
        .val_o        (val_w[gi]),
        .above_o      (above_w[gi]),
        .lt_o         (lt_w[gi]),
        .eq_o         (eq_w[gi])
      );
    end
  endgenerate

  sis_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_start),
    .lt_i    (lt_w),
    .pos_o   (pos),
    .done_o  (srch_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.ins_en) begin
        count_q <= count_q + sis_pkg::POS_W'(1);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_pos_q  <= pos;
      out_ins_q  <= ins;
      out_full_q <= full;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign insert_position_o = sis_pkg::OUT_POS_W'(out_pos_q);
  assign inserted_o        = out_ins_q;
  assign set_full_o        = out_full_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sis_pkg::POS_W'(sis_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_ins_q && out_full_q))
    else $error("inserted and set_full both set");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |=> count_q == $past(count_q) + sis_pkg::POS_W'(1))
    else $error("entry count did not advance on insert");

  a_commit_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (state_q == sis_pkg::ST_COMMIT) && out_free)
    else $error("commit without free output slot");
`endif

endmodule

@@ hw/rtl/sis_cell.sv @@
// One storage cell of the sorted chain: holds an id, compares it, shifts from its neighbor.
`timescale 1ns / 1ps

module sis_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sis_pkg::cell_ctrl_t     ctrl_i,
  input  logic [sis_pkg::ID_W-1:0] id_i,
  input  logic [sis_pkg::ID_W-1:0] left_val_i,
  input  logic                    left_above_i,
  input  logic                    tail_i,
  output logic [sis_pkg::ID_W-1:0] val_o,
  output logic                    above_o,
  output logic                    lt_o,
  output logic                    eq_o
);

  logic [sis_pkg::ID_W-1:0] val_q;
  logic                     vld_q;
  logic                     lt_q;
  logic                     eq_q;
  logic                     take;

  assign take = ctrl_i.ins_en && !lt_q && (vld_q || tail_i);

  always_ff @(posedge clk_i) begin
    if (take) begin
      val_q <= left_above_i ? left_val_i : id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      lt_q  <= 1'b0;
      eq_q  <= 1'b0;
    end else begin
      if (take) begin
        vld_q <= 1'b1;
      end
      if (ctrl_i.cmp_en) begin
        lt_q <= vld_q && (val_q < id_i);
        eq_q <= vld_q && (val_q == id_i);
      end
    end
  end

  assign val_o   = val_q;
  assign above_o = !lt_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

@@ hw/rtl/sis_search.sv @@
// Bit-serial search that turns the thermometer of less-than flags into a position.
`timescale 1ns / 1ps

module sis_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sis_pkg::CAPACITY-1:0] lt_i,
  output logic [sis_pkg::POS_W-1:0]   pos_o,
  output logic                        done_o
);

  logic [sis_pkg::POS_W-1:0]  pos_q;
  logic [sis_pkg::POS_W-1:0]  pos_d;
  logic [sis_pkg::STEP_W-1:0] step_q;
  logic                       run_q;
  logic                       done_q;
  logic [sis_pkg::POS_W-1:0]  cand;
  logic [sis_pkg::POS_W-1:0]  cand_m1;

  assign cand    = pos_q | (sis_pkg::POS_W'(1) << step_q);
  assign cand_m1 = cand - sis_pkg::POS_W'(1);

  always_comb begin
    pos_d = pos_q;
    if ((cand <= sis_pkg::POS_W'(sis_pkg::CAPACITY)) && lt_i[cand_m1[sis_pkg::IDX_W-1:0]]) begin
      pos_d = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      step_q <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        pos_q  <= '0;
        step_q <= sis_pkg::STEP_W'(sis_pkg::POS_W - 1);
        run_q  <= 1'b1;
      end else if (run_q) begin
        pos_q <= pos_d;
        if (step_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - sis_pkg::STEP_W'(1);
        end
      end
    end
  end

  assign pos_o  = pos_q;
  assign done_o = done_q;

endmodule
